// ===== src/fitness_selection_engine_macros.svh =====
// Assertion helpers shared by the engine RTL.
`ifndef FITNESS_SELECTION_ENGINE_MACROS_SVH
`define FITNESS_SELECTION_ENGINE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FSE_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define FSE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/fse_pkg.sv =====
`default_nettype none

package fse_pkg;

    localparam int MAX_POP = 256;
    localparam int IDX_W   = $clog2(MAX_POP);
    localparam int CNT_W   = IDX_W + 1;
    localparam int FIT_W   = 31;
    localparam int SUM_W   = FIT_W + IDX_W;
    localparam int DATA_W  = 32;
    localparam int RAND_W  = 32;
    localparam int MUL_W   = 2 * RAND_W;
    localparam int SH_W    = SUM_W - RAND_W;

    localparam logic [2:0] MODE_CLEAR      = 3'd0;
    localparam logic [2:0] MODE_LOAD       = 3'd1;
    localparam logic [2:0] MODE_ROULETTE   = 3'd2;
    localparam logic [2:0] MODE_TOURNAMENT = 3'd3;
    localparam logic [2:0] MODE_ELITE      = 3'd4;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    localparam logic [CNT_W-1:0] POP_FULL = CNT_W'(MAX_POP);

    typedef struct packed {
        logic [2:0]              mode;
        logic signed [DATA_W-1:0] fitness_value;
        logic [RAND_W-1:0]       rand_first;
        logic [RAND_W-1:0]       rand_second;
        logic                    exclude_enable;
        logic [IDX_W-1:0]        exclude_index;
    } fse_in_t;

    typedef struct packed {
        logic [IDX_W-1:0] chosen_index;
        logic [1:0]       status;
        logic [CNT_W-1:0] entry_total;
    } fse_out_t;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [FIT_W-1:0] wr_data;
        logic [IDX_W-1:0] rd_addr;
    } fse_store_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RMUL_LO,
        ST_RMUL_HI,
        ST_RTARGET,
        ST_SCAN,
        ST_TMUL_I,
        ST_TMUL_J,
        ST_TDRAW,
        ST_TREAD_J,
        ST_TCMP,
        ST_EZERO,
        ST_DONE
    } fse_state_t;

endpackage

`default_nettype wire

// ===== src/fitness_selection_engine.sv =====
`default_nettype none
`include "fitness_selection_engine_macros.svh"

// Fitness store and parent selector. Clear, load, an unused mode and any
// selection on an empty store pass from the request straight through the done
// state to the result register. Roulette and elite both walk the fitness
// memory one entry per cycle through its single registered read port.
// Tournament is paced by the one shared 32x32 registered multiplier (two
// draws) and two memory reads. A new request is taken once the previous one
// has left the sequencer, even if its result still waits on m_ready. The store
// needs no clearing after reset.
module fitness_selection_engine (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  fse_pkg::fse_in_t  s_req,
    output logic              m_valid,
    input  logic              m_ready,
    output fse_pkg::fse_out_t m_res
);
    import fse_pkg::*;

    fse_state_t       state_reg, state_next;
    fse_in_t          req_reg;
    logic [CNT_W-1:0] count_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0] scan_addr_reg;
    logic [CNT_W-1:0] scan_end_reg;
    logic             rd_vld_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [SUM_W-1:0] total_reg;
    logic [SUM_W-1:0] target_reg;
    logic [RAND_W-1:0] lo_hi_reg;
    logic             found_reg;
    logic [FIT_W-1:0] best_fit_reg;
    logic [IDX_W-1:0] ti_reg;
    logic [IDX_W-1:0] tj_reg;
    logic [FIT_W-1:0] fi_reg;
    logic [IDX_W-1:0] res_chosen_reg;
    logic [1:0]       res_status_reg;
    logic             m_valid_reg;
    fse_out_t         m_res_reg;

    logic             accept;
    logic             out_free;
    logic             is_empty;
    logic             is_full;
    logic             scan_issue;
    logic             scan_done;
    logic [FIT_W-1:0] load_val;
    logic [FIT_W-1:0] rd_data;
    logic [FIT_W-1:0] rd_eff;
    logic [SUM_W:0]   acc_sum;
    logic [IDX_W-1:0] draw_d;
    logic [RAND_W-1:0] mul_a;
    logic [RAND_W-1:0] mul_b;
    logic [MUL_W-1:0] mul_prod;
    fse_store_req_t   store_req;

    fse_store u_store (
        .aclk    (aclk),
        .req     (store_req),
        .rd_data (rd_data)
    );

    fse_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_prod)
    );

    assign accept     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign is_empty   = (count_reg == '0);
    assign is_full    = (count_reg == POP_FULL);
    assign scan_issue = (scan_addr_reg < scan_end_reg);
    assign scan_done  = !scan_issue && !rd_vld_reg;
    assign load_val   = s_req.fitness_value[DATA_W-1] ? '0 : s_req.fitness_value[FIT_W-1:0];
    assign rd_eff     = (req_reg.exclude_enable && rd_idx_reg == req_reg.exclude_index) ?
                        '0 : rd_data;
    assign acc_sum    = {1'b0, total_reg} + (SUM_W + 1)'(rd_eff);
    assign draw_d     = mul_prod[RAND_W +: IDX_W];

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_req.mode) inside
                        MODE_ROULETTE:   state_next = is_empty ? ST_DONE : ST_RMUL_LO;
                        MODE_TOURNAMENT: state_next = is_empty ? ST_DONE : ST_TMUL_I;
                        MODE_ELITE:      state_next = is_empty ? ST_DONE : ST_SCAN;
                        default:         state_next = ST_DONE;
                    endcase
                end
            end
            ST_RMUL_LO: state_next = ST_RMUL_HI;
            ST_RMUL_HI: state_next = ST_RTARGET;
            ST_RTARGET: state_next = ST_SCAN;
            ST_SCAN: begin
                if (scan_done) begin
                    state_next = (req_reg.mode == MODE_ELITE) ? ST_EZERO : ST_DONE;
                end
            end
            ST_TMUL_I:  state_next = ST_TMUL_J;
            ST_TMUL_J:  state_next = ST_TDRAW;
            ST_TDRAW:   state_next = ST_TREAD_J;
            ST_TREAD_J: state_next = ST_TCMP;
            ST_TCMP:    state_next = ST_DONE;
            ST_EZERO:   state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready           = 1'b0;
        mul_a             = req_reg.rand_first;
        mul_b             = '0;
        store_req.wr_en   = 1'b0;
        store_req.wr_addr = count_reg[IDX_W-1:0];
        store_req.wr_data = load_val;
        store_req.rd_addr = scan_addr_reg[IDX_W-1:0];
        unique case (state_reg)
            ST_IDLE: begin
                s_ready         = 1'b1;
                store_req.wr_en = s_valid && s_req.mode == MODE_LOAD && !is_full;
            end
            ST_RMUL_LO: mul_b = sum_reg[RAND_W-1:0];
            ST_RMUL_HI: mul_b = RAND_W'(sum_reg[SUM_W-1:RAND_W]);
            ST_TMUL_I:  mul_b = RAND_W'(count_reg);
            ST_TMUL_J: begin
                mul_a = req_reg.rand_second;
                mul_b = RAND_W'(count_reg - 1'b1);
            end
            ST_TDRAW:   store_req.rd_addr = ti_reg;
            ST_TREAD_J: store_req.rd_addr = tj_reg;
            ST_EZERO: begin
                store_req.wr_en   = 1'b1;
                store_req.wr_addr = res_chosen_reg;
                store_req.wr_data = '0;
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            sum_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rd_vld_reg <= (state_reg == ST_SCAN) && scan_issue;
            if (accept && s_req.mode == MODE_CLEAR) begin
                count_reg <= '0;
                sum_reg   <= '0;
            end else if (accept && s_req.mode == MODE_LOAD && !is_full) begin
                count_reg <= count_reg + 1'b1;
                sum_reg   <= sum_reg + SUM_W'(load_val);
            end
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        rd_idx_reg <= store_req.rd_addr;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    req_reg        <= s_req;
                    scan_addr_reg  <= '0;
                    total_reg      <= '0;
                    found_reg      <= 1'b0;
                    if (s_req.mode == MODE_ROULETTE) begin
                        scan_end_reg <= count_reg - 1'b1;
                    end else begin
                        scan_end_reg <= count_reg;
                    end
                    if (s_req.mode == MODE_ROULETTE && !is_empty) begin
                        res_chosen_reg <= IDX_W'(count_reg - 1'b1);
                    end else begin
                        res_chosen_reg <= '0;
                    end
                    if (s_req.mode == MODE_LOAD && is_full) begin
                        res_status_reg <= STATUS_FULL;
                    end else if (is_empty && (s_req.mode == MODE_ROULETTE ||
                                 s_req.mode == MODE_TOURNAMENT ||
                                 s_req.mode == MODE_ELITE)) begin
                        res_status_reg <= STATUS_EMPTY;
                    end else begin
                        res_status_reg <= STATUS_OK;
                    end
                end
            end
            ST_RMUL_HI: lo_hi_reg <= mul_prod[MUL_W-1:RAND_W];
            ST_RTARGET: target_reg <= mul_prod[SUM_W-1:0] + SUM_W'(lo_hi_reg);
            ST_SCAN: begin
                if (scan_issue) begin
                    scan_addr_reg <= scan_addr_reg + 1'b1;
                end
                if (rd_vld_reg) begin
                    if (req_reg.mode == MODE_ELITE) begin
                        if (rd_idx_reg == '0 || rd_eff > best_fit_reg) begin
                            best_fit_reg   <= rd_eff;
                            res_chosen_reg <= rd_idx_reg;
                        end
                    end else begin
                        total_reg <= acc_sum[SUM_W-1:0];
                        if (!found_reg && total_reg < target_reg &&
                            {1'b0, target_reg} < acc_sum) begin
                            found_reg      <= 1'b1;
                            res_chosen_reg <= rd_idx_reg;
                        end
                    end
                end
            end
            ST_TMUL_J: ti_reg <= draw_d;
            ST_TDRAW: begin
                if (count_reg == CNT_W'(1)) begin
                    tj_reg <= ti_reg;
                end else if (draw_d >= ti_reg) begin
                    tj_reg <= draw_d + 1'b1;
                end else begin
                    tj_reg <= draw_d;
                end
            end
            ST_TREAD_J: fi_reg <= rd_eff;
            ST_TCMP:    res_chosen_reg <= (fi_reg > rd_eff) ? ti_reg : tj_reg;
            ST_DONE: begin
                if (out_free) begin
                    m_res_reg.chosen_index <= res_chosen_reg;
                    m_res_reg.status       <= res_status_reg;
                    m_res_reg.entry_total  <= count_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;

    `FSE_ASSERT_NEXT(a_load_counts, aclk, aresetn, accept && s_req.mode == MODE_LOAD && !is_full, count_reg == $past(count_reg) + 1'b1, "load did not advance entry count")
    `FSE_ASSERT_SAME(a_empty_zero, aclk, aresetn, m_valid && m_res.status == STATUS_EMPTY, m_res.chosen_index == '0 && m_res.entry_total == '0, "empty result with nonzero index or count")
    `FSE_ASSERT_SAME(a_index_in_range, aclk, aresetn, m_valid && m_res.entry_total != '0, CNT_W'(m_res.chosen_index) < m_res.entry_total, "chosen index beyond stored entries")
    `FSE_ASSERT_SAME(a_read_in_scan, aclk, aresetn, rd_vld_reg, state_reg == ST_SCAN, "scan read returned outside scan")

endmodule

`default_nettype wire

// ===== src/fse_store.sv =====
`default_nettype none

module fse_store (
    input  logic                        aclk,
    input  fse_pkg::fse_store_req_t     req,
    output logic [fse_pkg::FIT_W-1:0]   rd_data
);
    import fse_pkg::*;

    logic [FIT_W-1:0] mem [MAX_POP];
    logic [FIT_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[req.rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== src/fse_mul.sv =====
`default_nettype none

module fse_mul (
    input  logic                        aclk,
    input  logic [fse_pkg::RAND_W-1:0]  op_a,
    input  logic [fse_pkg::RAND_W-1:0]  op_b,
    output logic [fse_pkg::MUL_W-1:0]   prod
);
    import fse_pkg::*;

    logic [MUL_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= MUL_W'(op_a) * MUL_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire
